// ===== sv/sqep_pkg.sv =====
// Shared types, constants and codes for the servo quadratic ease profile unit.
package sqep_pkg;

  // Field widths and limits
  localparam int unsigned ANGLE_W     = 8;
  localparam int unsigned TIME_W      = 17;
  localparam int unsigned CMD_W       = 2;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned MAX_ANGLE   = 180;
  localparam int unsigned HOME_ANGLE  = 90;
  localparam int unsigned FRAC_BITS   = 24;
  localparam int unsigned SWEEP_MIN   = 100;
  localparam int unsigned SWEEP_MAX   = 100000;
  localparam int unsigned SWEEP_RESET = 1000;

  // Stream word layout
  localparam int unsigned IN_TDATA_W  = ((ANGLE_W + TIME_W + 7) / 8) * 8;
  localparam int unsigned OUT_FIELD_W = ANGLE_W + 1 + 1 + STATUS_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  // Divider: elapsed time scaled by 2^FRAC_BITS over a duration
  localparam int unsigned DIV_W    = TIME_W + FRAC_BITS;
  localparam int unsigned DIVCNT_W = $clog2(DIV_W + 1);
  localparam int unsigned FRAC1_W  = FRAC_BITS + 1;
  localparam int unsigned PROD_W   = ANGLE_W + FRAC1_W;

  // Scaled duration: divide by MAX_ANGLE through a reciprocal multiply,
  // exact for every sweep time and angle distance in range
  localparam int unsigned     SPROD_W     = ANGLE_W + TIME_W;
  localparam int unsigned     SCALE_SHIFT = 33;
  localparam longint unsigned RECIP_VAL   =
    ((64'd1 << SCALE_SHIFT) + MAX_ANGLE - 1) / MAX_ANGLE;
  localparam int unsigned     RECIP_W     = $clog2(RECIP_VAL + 1);
  localparam logic [RECIP_W-1:0] SCALE_RECIP = RECIP_W'(RECIP_VAL);
  localparam int unsigned     SCALED_W    = SPROD_W + RECIP_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK        = 2'd0,
    CMD_MOVE_SCALED = 2'd1,
    CMD_MOVE_GIVEN  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    DIR_STILL = 2'd0,
    DIR_UP    = 2'd1,
    DIR_DOWN  = 2'd2
  } dir_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_BAD_TARGET = 2'd1,
    ST_ZERO_TIME  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_SCALE_WB,
    S_DIV_EASE,
    S_SQ,
    S_ANG,
    S_FIN
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic commit_simple;
    logic start_scale;
    logic start_ease;
    logic div_step;
    logic commit_scale;
    logic mul_sq;
    logic mul_ang;
    logic commit_ease;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_scale;
    logic need_ease;
    logic div_done;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== sv/sqep_ctrl.sv =====
// Sequencing state machine for the servo quadratic ease profile unit.
module sqep_ctrl
  import sqep_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EVAL;
        end
      end
      S_EVAL: begin
        if (sts_i.need_scale) begin
          cmd_o.start_scale = 1'b1;
          state_d           = S_SCALE_WB;
        end else if (sts_i.need_ease) begin
          cmd_o.start_ease = 1'b1;
          state_d          = S_DIV_EASE;
        end else if (sts_i.out_free) begin
          cmd_o.commit_simple = 1'b1;
          state_d             = S_IDLE;
        end
      end
      S_SCALE_WB: begin
        if (sts_i.out_free) begin
          cmd_o.commit_scale = 1'b1;
          state_d            = S_IDLE;
        end
      end
      S_DIV_EASE: begin
        if (sts_i.div_done) begin
          state_d = S_SQ;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      S_SQ: begin
        cmd_o.mul_sq = 1'b1;
        state_d      = S_ANG;
      end
      S_ANG: begin
        cmd_o.mul_ang = 1'b1;
        state_d       = S_FIN;
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.commit_ease = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/sqep_datapath.sv =====
// Motion state, restoring divider, ease multipliers and output register.
module sqep_datapath
  import sqep_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [TIME_W-1:0]      cfg_wdata_i,
  input  logic [IN_TDATA_W-1:0]  in_data_i,
  input  logic [CMD_W-1:0]       in_cmd_i,
  input  dp_cmd_t                cmd_i,
  output dp_sts_t                sts_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [OUT_TDATA_W-1:0] out_data_o
);

  localparam logic [DIV_W-1:0]   ONE_DIV = DIV_W'(1) << FRAC_BITS;
  localparam logic [FRAC1_W-1:0] ONE     = FRAC1_W'(1) << FRAC_BITS;
  localparam logic [FRAC1_W-1:0] HALF    = FRAC1_W'(1) << (FRAC_BITS - 1);

  // Architectural state
  logic [TIME_W-1:0]  sweep_q, sweep_d;
  logic [ANGLE_W-1:0] cur_q, cur_d;
  logic [ANGLE_W-1:0] start_q, start_d;
  logic [ANGLE_W-1:0] end_q, end_d;
  logic [TIME_W-1:0]  dur_q, dur_d;
  logic [TIME_W-1:0]  elapsed_q, elapsed_d;
  logic               started_q, started_d;
  dir_e               dir_q, dir_d;

  // Captured word
  cmd_e               cmd_q;
  logic [ANGLE_W-1:0] tgt_q;
  logic [TIME_W-1:0]  ms_q;

  // Divider
  logic [TIME_W-1:0]   div_rem_q, div_rem_d;
  logic [DIV_W-1:0]    div_quo_q, div_quo_d;
  logic [TIME_W-1:0]   div_den_q, div_den_d;
  logic [DIVCNT_W-1:0] div_cnt_q, div_cnt_d;
  logic [TIME_W:0]     div_shift;
  logic [TIME_W:0]     div_trial;
  logic                div_ge;

  // Scaled duration
  logic [SPROD_W-1:0]  sweep_prod_q;
  logic [SCALED_W-1:0] scaled_prod;

  // Ease pipeline
  logic [FRAC_BITS-1:0] sq_q;
  logic                 lt_q;
  logic [PROD_W-1:0]    prod_q;

  // Output register
  logic                   out_valid_q, out_valid_d;
  logic [OUT_TDATA_W-1:0] out_data_q;

  // Decode helpers
  logic                      tgt_ok, tick_live, tick_snap, given;
  logic [ANGLE_W-1:0]        move_diff, seg_diff, seg_lo, new_angle;
  logic [ANGLE_W+TIME_W-1:0] sweep_prod;
  logic [TIME_W-1:0]         elapsed_next;
  logic [FRAC1_W-1:0]        tq, n_val;
  logic                      tq_lt;
  logic [FRAC_BITS-1:0]      x_val;
  logic [2*FRAC_BITS-1:0]    x_sq;
  logic [ANGLE_W:0]          seg_step;
  logic                      res_written, out_load;
  status_e                   res_status;

  // Classify the captured word against the motion state
  always_comb begin
    given        = (cmd_q == CMD_MOVE_GIVEN);
    tgt_ok       = (tgt_q <= ANGLE_W'(MAX_ANGLE));
    move_diff    = (cur_q > tgt_q) ? (cur_q - tgt_q) : (tgt_q - cur_q);
    sweep_prod   = sweep_q * move_diff;
    scaled_prod  = sweep_prod_q * SCALE_RECIP;
    tick_live    = (dir_q != DIR_STILL) && (start_q != end_q);
    tick_snap    = started_q ? (elapsed_q >= dur_q) : (dur_q == '0);
    elapsed_next = started_q ? TIME_W'(elapsed_q + 1'b1) : '0;
    seg_lo       = (start_q < end_q) ? start_q : end_q;
    seg_diff     = (start_q > end_q) ? (start_q - end_q) : (end_q - start_q);
  end

  assign sts_o.need_scale = (cmd_q == CMD_MOVE_SCALED) && tgt_ok && (tgt_q != cur_q);
  assign sts_o.need_ease  = (cmd_q == CMD_TICK) && tick_live && !tick_snap;
  assign sts_o.div_done   = (div_cnt_q == '0);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  // One restoring divide step per cycle
  always_comb begin
    div_shift = {div_rem_q, div_quo_q[DIV_W-1]};
    div_trial = div_shift - {1'b0, div_den_q};
    div_ge    = (div_shift >= {1'b0, div_den_q});
    div_rem_d = div_rem_q;
    div_quo_d = div_quo_q;
    div_den_d = div_den_q;
    div_cnt_d = div_cnt_q;
    if (cmd_i.start_ease) begin
      div_rem_d = '0;
      div_quo_d = DIV_W'(elapsed_next) << FRAC_BITS;
      div_den_d = dur_q;
      div_cnt_d = DIVCNT_W'(DIV_W);
    end else if (cmd_i.div_step) begin
      div_rem_d = div_ge ? div_trial[TIME_W-1:0] : div_shift[TIME_W-1:0];
      div_quo_d = {div_quo_q[DIV_W-2:0], div_ge};
      div_cnt_d = div_cnt_q - 1'b1;
    end
  end

  // Eased fraction and angle
  always_comb begin
    tq       = (div_quo_q > ONE_DIV) ? ONE : div_quo_q[FRAC1_W-1:0];
    tq_lt    = (tq < HALF);
    x_val    = tq_lt ? tq[FRAC_BITS-1:0] : FRAC_BITS'(ONE - tq);
    x_sq     = x_val * x_val;
    if (dir_q == DIR_UP) begin
      n_val = lt_q ? FRAC1_W'(sq_q) : (ONE - FRAC1_W'(sq_q));
    end else begin
      n_val = lt_q ? (ONE - FRAC1_W'(sq_q)) : FRAC1_W'(sq_q);
    end
    seg_step  = (ANGLE_W + 1)'(prod_q >> FRAC_BITS);
    new_angle = ANGLE_W'(seg_lo + seg_step);
  end

  // Next motion state and result fields
  always_comb begin
    sweep_d     = sweep_q;
    cur_d       = cur_q;
    start_d     = start_q;
    end_d       = end_q;
    dur_d       = dur_q;
    elapsed_d   = elapsed_q;
    started_d   = started_q;
    dir_d       = dir_q;
    res_written = 1'b0;
    res_status  = ST_OK;

    if (cfg_we_i && (cfg_wdata_i >= TIME_W'(SWEEP_MIN)) &&
        (cfg_wdata_i <= TIME_W'(SWEEP_MAX))) begin
      sweep_d = cfg_wdata_i;
    end

    if (cmd_i.commit_simple) begin
      case (cmd_q)
        CMD_TICK: begin
          // Snap to the target: past the duration, or a move of zero duration
          if (tick_live) begin
            if (!started_q) begin
              elapsed_d = '0;
            end
            start_d     = end_q;
            started_d   = 1'b0;
            dir_d       = DIR_STILL;
            cur_d       = end_q;
            res_written = 1'b1;
          end
        end
        CMD_MOVE_SCALED, CMD_MOVE_GIVEN: begin
          if (!tgt_ok) begin
            res_status = ST_BAD_TARGET;
          end else if (given && (ms_q == '0)) begin
            res_status = ST_ZERO_TIME;
          end else begin
            start_d = cur_q;
            if (tgt_q != cur_q) begin
              end_d     = tgt_q;
              dur_d     = ms_q;
              started_d = 1'b0;
              dir_d     = (cur_q < tgt_q) ? DIR_UP : DIR_DOWN;
            end
          end
        end
        default: begin
        end
      endcase
    end

    if (cmd_i.start_scale) begin
      start_d   = cur_q;
      end_d     = tgt_q;
      started_d = 1'b0;
      dir_d     = (cur_q < tgt_q) ? DIR_UP : DIR_DOWN;
    end

    if (cmd_i.commit_scale) begin
      dur_d = TIME_W'(scaled_prod >> SCALE_SHIFT);
    end

    if (cmd_i.start_ease) begin
      started_d = 1'b1;
      elapsed_d = elapsed_next;
    end

    if (cmd_i.commit_ease) begin
      cur_d       = new_angle;
      res_written = 1'b1;
    end
  end

  // Output word handshake
  assign out_load    = cmd_i.commit_simple || cmd_i.commit_scale || cmd_i.commit_ease;
  assign out_valid_d = out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q     <= TIME_W'(SWEEP_RESET);
      cur_q       <= ANGLE_W'(HOME_ANGLE);
      start_q     <= ANGLE_W'(HOME_ANGLE);
      end_q       <= ANGLE_W'(HOME_ANGLE);
      dur_q       <= '0;
      elapsed_q   <= '0;
      started_q   <= 1'b0;
      dir_q       <= DIR_STILL;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      sweep_q     <= sweep_d;
      cur_q       <= cur_d;
      start_q     <= start_d;
      end_q       <= end_d;
      dur_q       <= dur_d;
      elapsed_q   <= elapsed_d;
      started_q   <= started_d;
      dir_q       <= dir_d;
      div_cnt_q   <= div_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    div_rem_q <= div_rem_d;
    div_quo_q <= div_quo_d;
    div_den_q <= div_den_d;
    if (cmd_i.capture) begin
      cmd_q <= cmd_e'(in_cmd_i);
      tgt_q <= in_data_i[ANGLE_W-1:0];
      ms_q  <= in_data_i[ANGLE_W +: TIME_W];
    end
    if (cmd_i.start_scale) begin
      sweep_prod_q <= sweep_prod;
    end
    if (cmd_i.mul_sq) begin
      sq_q <= FRAC_BITS'(x_sq >> (FRAC_BITS - 1));
      lt_q <= tq_lt;
    end
    if (cmd_i.mul_ang) begin
      prod_q <= seg_diff * n_val;
    end
    if (out_load) begin
      out_data_q <= OUT_TDATA_W'({res_status, (dir_d != DIR_STILL), res_written, cur_d});
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== sv/servo_quadratic_ease_profile_unit.sv =====
// Top level of the servo quadratic ease profile unit.
//
// Slave stream: one word per one-millisecond tick or move command. tuser
// carries the command, tdata the target angle and the given duration.
// Master stream: one word per accepted input word with the angle, a flag
// that a new angle was written, the moving flag and the status code.
// The sweep time register is written through cfg_we_i / cfg_wdata_i; the
// user writes it only while no word is in flight, which the block itself
// does not enforce. Values outside 100 to 100000 ms are dropped. Moves
// with a given duration, rejected moves and ticks that snap or do nothing
// are committed from the evaluate state; a move with a scaled duration
// takes an extra state that scales the sweep time by a reciprocal multiply.
// An easing tick runs the 41-step divider that retires one quotient bit
// per cycle, followed by the square and scale multiplies. One word is
// worked at a time; the next is taken only once the previous
// result is registered. The result sits in an output register,
// so a stalled receiver holds only the next result: the block stays in its
// final step until the register frees. Reset returns the servo to 90
// degrees at rest, sweep time 1000 ms.
module servo_quadratic_ease_profile_unit
  import sqep_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [TIME_W-1:0]      cfg_wdata_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [7:0] target_angle, [24:8] move_time_ms, rest zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // [1:0] command
  input  logic [CMD_W-1:0]       s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [7:0] angle, [8] angle_written, [9] moving, [11:10] status, rest zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  sqep_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (dp_sts),
    .cmd_o      (dp_cmd)
  );

  sqep_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (s_axis_tdata),
    .in_cmd_i    (s_axis_tuser),
    .cmd_i       (dp_cmd),
    .sts_o       (dp_sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

// ===== sv/sqep_checker.sv =====
// Port-level checks for the servo quadratic ease profile unit.
module sqep_checker
  import sqep_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // Angle stays within the servo range
  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[ANGLE_W-1:0] <= ANGLE_W'(MAX_ANGLE))
    else $error("angle above range");

  // Status never carries the unused code
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[ANGLE_W+3:ANGLE_W+2] != 2'd3)
    else $error("unused status code");

  // A written angle only comes with ok status
  a_write_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[ANGLE_W] |-> m_axis_tdata[ANGLE_W+3:ANGLE_W+2] == ST_OK)
    else $error("angle written with error status");

endmodule

bind servo_quadratic_ease_profile_unit sqep_checker u_sqep_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
